/* design/cfa_pkg.sv */
package cfa_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int SIZE_W     = 12;
    localparam int POS_W      = 11;
    localparam int BANK_AW    = POS_W - 1;
    localparam int BANK_DEPTH = MAX_WIDTH / 2;
    localparam int REG_AW     = 4;

    localparam logic FMT_YUV = 1'b0;
    localparam logic FMT_RAW = 1'b1;

    localparam logic [7:0]  ALPHA_YUV  = 8'h80;
    localparam logic [7:0]  ALPHA_RAW  = 8'hFF;
    localparam logic [15:0] SAMPLE_MAX = 16'd4095;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd1280;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd800;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    // sizes already limited to the legal range and made even
    typedef struct packed {
        logic              fmt;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic             quad;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [7:0]       y0;
        logic [7:0]       u;
        logic [7:0]       y1;
        logic [7:0]       v;
        logic [7:0]       s8;
        logic [7:0]       g_left;
        logic [7:0]       g_up;
        logic [7:0]       blue;
    } t_item;

    function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] t;
        t = v;
        if (t < SIZE_W'(2)) t = SIZE_W'(2);
        if (t > maxv) t = maxv;
        return {t[SIZE_W-1:1], 1'b0};
    endfunction

    function automatic logic [7:0] clamp_chan(input logic signed [19:0] v);
        logic [11:0] q;
        q = v[19:8];
        if (v < 0) return 8'd0;
        if (q > 12'd255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic logic [31:0] yuv_pixel(input logic [7:0] y, input logic [7:0] u,
                                              input logic [7:0] v);
        logic signed [19:0] c, d, e, r, g, b;
        c = $signed({12'b0, y}) - 20'sd16;
        d = $signed({12'b0, u}) - 20'sd128;
        e = $signed({12'b0, v}) - 20'sd128;
        r = 20'sd298 * c + 20'sd409 * e + 20'sd128;
        g = 20'sd298 * c - 20'sd100 * d - 20'sd208 * e + 20'sd128;
        b = 20'sd298 * c + 20'sd516 * d + 20'sd128;
        return {ALPHA_YUV, clamp_chan(r), clamp_chan(g), clamp_chan(b)};
    endfunction

endpackage

/* design/camera_frame_to_argb_unit.sv */
// Camera stream to ARGB pixel converter.
// Input channel: one request per pixel_word (i_in_valid / o_in_stall). In YUV422
// mode a word gives two pixels (alpha 0x80); in RAW16 Bayer mode a word is one
// BGGR sample, and the sample at each odd row, odd column gives the four pixels
// of its 2x2 quad (alpha 0xFF). Other RAW samples give no pixel.
// Output channel: one pixel per request (o_out_valid / i_out_stall) with its
// column, row, and o_last on the final pixel of each input word.
// Configuration: APB registers pixel_format (0x0), frame_width (0x4) and
// frame_height (0x8); write them only while the block is idle.
// With the output free, a taken word is held in the front register and is
// then loaded into the output register, which offers its first pixel.
// The output register delivers one pixel per cycle while the receiver does not
// stall; a new word is taken while the front register is empty, or in the cycle
// the output register's last pixel leaves. A RAW sample with no pixel leaves the
// front register empty. When the receiver stalls, the pixel on the outputs holds
// and the input side stalls once one further word is waiting. Reset clears
// position counters, held green and the pipeline; the line store is not cleared,
// and a quad reads the entries last written at its column pair on an even row.
module camera_frame_to_argb_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfa_pkg::REG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [31:0]                 i_pixel_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_pixel_color,
    output logic [cfa_pkg::POS_W-1:0]   o_column,
    output logic [cfa_pkg::POS_W-1:0]   o_row,
    output logic                        o_last
);
    import cfa_pkg::*;

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  take;

    cfa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .i_pixel_word (i_pixel_word),
        .o_in_stall   (o_in_stall),
        .i_take       (take),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    cfa_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_take        (take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_last        (o_last)
    );

endmodule

/* design/cfa_regs.sv */
module cfa_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfa_pkg::REG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output cfa_pkg::t_cfg               o_cfg
);
    import cfa_pkg::*;

    logic              r_format;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    t_reg_idx          reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[REG_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_YUV;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FORMAT: r_format <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FORMAT: prdata = {31'd0, r_format};
            REG_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.fmt    = r_format;
    assign o_cfg.width  = limit_size(r_width, SIZE_W'(MAX_WIDTH));
    assign o_cfg.height = limit_size(r_height, SIZE_W'(MAX_HEIGHT));

endmodule

/* design/cfa_front.sv */
module cfa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfa_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    input  logic [31:0]    i_pixel_word,
    output logic           o_in_stall,
    input  logic           i_take,
    output logic           o_item_valid,
    output cfa_pkg::t_item o_item
);
    import cfa_pkg::*;

    logic [POS_W-1:0]  r_col, r_row;
    logic [7:0]        r_held_green;
    logic              r_s1_valid;
    t_item             r_s1;
    logic [7:0]        even_bank [BANK_DEPTH];
    logic [7:0]        odd_bank  [BANK_DEPTH];

    logic              accept;
    logic [POS_W-1:0]  cx, cy, x_eff;
    logic [SIZE_W-1:0] nx_wide, ny_wide;
    logic [POS_W-1:0]  n_col, n_row;
    logic              is_raw, produces;
    logic [15:0]       sample;
    logic [7:0]        s8;
    logic [BANK_AW-1:0] bank_addr;

    assign o_in_stall = r_s1_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_raw     = (i_cfg.fmt == FMT_RAW);

    always_comb begin
        cx = ({1'b0, r_col} >= i_cfg.width)  ? '0 : r_col;
        cy = ({1'b0, r_row} >= i_cfg.height) ? '0 : r_row;
        x_eff = is_raw ? cx : {cx[POS_W-1:1], 1'b0};
        nx_wide = {1'b0, x_eff} + (is_raw ? SIZE_W'(1) : SIZE_W'(2));
        ny_wide = {1'b0, cy};
        if (nx_wide >= i_cfg.width) begin
            nx_wide = '0;
            ny_wide = ny_wide + SIZE_W'(1);
            if (ny_wide >= i_cfg.height) ny_wide = '0;
        end
        n_col = nx_wide[POS_W-1:0];
        n_row = ny_wide[POS_W-1:0];
    end

    assign sample    = i_pixel_word[15:0];
    assign s8        = (sample > SAMPLE_MAX) ? 8'hFF : sample[11:4];
    assign produces  = !is_raw || (cy[0] && cx[0]);
    assign bank_addr = cx[POS_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_held_green <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= produces;
                if (is_raw && cy[0] && !cx[0]) r_held_green <= s8;
            end else if (i_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // even-row samples split by column parity; a quad reads both at one index
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.quad   <= is_raw;
            r_s1.col    <= x_eff;
            r_s1.row    <= cy;
            r_s1.y0     <= i_pixel_word[7:0];
            r_s1.u      <= i_pixel_word[15:8];
            r_s1.y1     <= i_pixel_word[23:16];
            r_s1.v      <= i_pixel_word[31:24];
            r_s1.s8     <= s8;
            r_s1.g_left <= r_held_green;
            r_s1.g_up   <= odd_bank[bank_addr];
            r_s1.blue   <= even_bank[bank_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_raw && !cy[0] && !cx[0]) even_bank[bank_addr] <= s8;
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_raw && !cy[0] && cx[0]) odd_bank[bank_addr] <= s8;
    end

    assign o_item       = r_s1;
    assign o_item_valid = r_s1_valid;

endmodule

/* design/cfa_out.sv */
module cfa_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  cfa_pkg::t_item              i_item,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_pixel_color,
    output logic [cfa_pkg::POS_W-1:0]   o_column,
    output logic [cfa_pkg::POS_W-1:0]   o_row,
    output logic                        o_last
);
    import cfa_pkg::*;

    logic             r_valid;
    logic [1:0]       r_idx, r_last_idx;
    logic [31:0]      r_px  [4];
    logic [POS_W-1:0] r_col [4];
    logic [POS_W-1:0] r_row [4];

    logic [31:0]      n_px  [4];
    logic [POS_W-1:0] n_col [4];
    logic [POS_W-1:0] n_row [4];
    logic [1:0]       n_last_idx;
    logic             deliver, burst_done;
    logic [31:0]      quad_up, quad_lo;
    logic [POS_W-1:0] col_m1, row_m1;

    assign deliver    = r_valid && !i_out_stall;
    assign burst_done = deliver && (r_idx == r_last_idx);
    assign o_take     = !r_valid || burst_done;

    always_comb begin
        quad_up = {ALPHA_RAW, i_item.s8, i_item.g_up, i_item.blue};
        quad_lo = {ALPHA_RAW, i_item.s8, i_item.g_left, i_item.blue};
        col_m1  = i_item.col - POS_W'(1);
        row_m1  = i_item.row - POS_W'(1);
        if (i_item.quad) begin
            n_px  = '{quad_up, quad_up, quad_lo, quad_lo};
            n_col = '{col_m1, i_item.col, col_m1, i_item.col};
            n_row = '{row_m1, row_m1, i_item.row, i_item.row};
            n_last_idx = 2'd3;
        end else begin
            n_px[0]  = yuv_pixel(i_item.y0, i_item.u, i_item.v);
            n_px[1]  = yuv_pixel(i_item.y1, i_item.u, i_item.v);
            n_px[2]  = n_px[1];
            n_px[3]  = n_px[1];
            n_col[0] = i_item.col;
            n_col[1] = i_item.col + POS_W'(1);
            n_col[2] = n_col[1];
            n_col[3] = n_col[1];
            n_row    = '{i_item.row, i_item.row, i_item.row, i_item.row};
            n_last_idx = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_take) begin
            r_valid <= i_item_valid;
            r_idx   <= '0;
        end else if (deliver) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item_valid) begin
            r_px       <= n_px;
            r_col      <= n_col;
            r_row      <= n_row;
            r_last_idx <= n_last_idx;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_pixel_color = r_px[r_idx];
    assign o_column      = r_col[r_idx];
    assign o_row         = r_row[r_idx];
    assign o_last        = (r_idx == r_last_idx);

endmodule

/* design/cfa_chk.sv */
module cfa_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [31:0]                 o_pixel_color,
    input logic [cfa_pkg::POS_W-1:0]   o_column,
    input logic [cfa_pkg::POS_W-1:0]   o_row,
    input logic                        o_last
);

    // a stalled pixel request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_color)
            && $stable(o_column) && $stable(o_row) && $stable(o_last))
        else $error("output request changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // pixels of one word follow without a gap
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("gap inside a pixel burst");

    a_burst_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=>
            (o_row == $past(o_row)) || (o_row == $past(o_row) + 11'd1))
        else $error("row jumps inside a pixel burst");

    // input backs up only behind a pending pixel
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output pending");

endmodule

bind camera_frame_to_argb_unit cfa_chk u_cfa_chk (.*);

/* verif/camera_frame_to_argb_unit_test.sv */
module camera_frame_to_argb_unit_test;
    import cfa_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 80;
    localparam int PLAN_ROWS     = 34;
    localparam int PHASES        = 9;
    localparam int FILL_WIDTH    = 24;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [31:0]      color;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } t_pixel;

    typedef enum logic {PLAN_WORD, PLAN_WRITE} t_plan_kind;

    // one directed step: a request word, or a register write between requests
    typedef struct packed {
        t_plan_kind  kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        typed;
        logic [31:0] color;
    } t_plan_step;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [REG_AW-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [31:0]          i_pixel_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [31:0]          o_pixel_color;
    logic [POS_W-1:0]     o_column;
    logic [POS_W-1:0]     o_row;
    logic                 o_last;

    // converter state as the testbench sees it
    logic                 fmt_reg;
    logic [SIZE_W-1:0]    width_reg;
    logic [SIZE_W-1:0]    height_reg;
    logic [7:0]           line_store [MAX_WIDTH];
    int                   col_pos;
    int                   row_pos;
    logic [7:0]           green_hold;

    t_pixel               expected_pixels [$];
    t_pixel               oldest;
    t_plan_step           directed_plan [PLAN_ROWS];
    int                   mismatches = 0;
    int                   cycle_count = 0;
    int                   sender_gap_pct = 0;
    int                   receiver_stall_pct = 0;
    int                   hold_requests = 0;
    int                   holds_served = 0;
    int                   hold_left = 0;

    camera_frame_to_argb_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_word  (i_pixel_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
                     expected_pixels.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int fit_size(input logic [SIZE_W-1:0] v, input int top);
        int s;
        s = v;
        if (s < 2) s = 2;
        if (s > top) s = top;
        return s & ~1;
    endfunction

    function automatic logic [7:0] chan8(input int acc);
        if (acc < 0) return 8'd0;
        if ((acc >>> 8) > 255) return 8'hFF;
        return 8'(acc >>> 8);
    endfunction

    function automatic logic [31:0] bt601_argb(input logic [7:0] y, input logic [7:0] u,
                                               input logic [7:0] v);
        int c, d, e;
        c = int'(y) - 16;
        d = int'(u) - 128;
        e = int'(v) - 128;
        return {ALPHA_YUV, chan8(298 * c + 409 * e + 128),
                chan8(298 * c - 100 * d - 208 * e + 128), chan8(298 * c + 516 * d + 128)};
    endfunction

    function automatic logic [31:0] random_word(input logic raw);
        logic [31:0] w;
        w = $urandom;
        if (raw == FMT_RAW) begin
            case ($urandom_range(5))
                0: w[15:0] = 16'($urandom_range(4095));
                1: w[15:0] = 16'($urandom_range(4094, 4097));
                2: w[15:0] = 16'hFFFF;
                default: ;
            endcase
        end else if ($urandom_range(5) == 0) begin
            w[7:0]   = 8'hFF;
            w[23:16] = 8'h00;
        end
        return w;
    endfunction

    task automatic push_pixel(input logic [31:0] color, input int col, input int row,
                              input logic last);
        t_pixel p;
        p.color = color;
        p.col   = POS_W'(col);
        p.row   = POS_W'(row);
        p.last  = last;
        expected_pixels.push_back(p);
    endtask

    task automatic predict_word(input logic [31:0] word, input logic typed,
                                input logic [31:0] typed_color);
        int          w, h, x, y;
        logic [15:0] sample;
        logic [7:0]  s8, blue, g_up;
        logic [31:0] c0, c1;
        w = fit_size(width_reg, MAX_WIDTH);
        h = fit_size(height_reg, MAX_HEIGHT);
        // counters left beyond a shrunken frame restart at zero
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        x = col_pos;
        y = row_pos;
        if (fmt_reg == FMT_YUV) begin
            x = x & ~1;
            c0 = typed ? typed_color : bt601_argb(word[7:0], word[15:8], word[31:24]);
            c1 = typed ? typed_color : bt601_argb(word[23:16], word[15:8], word[31:24]);
            push_pixel(c0, x, y, 1'b0);
            push_pixel(c1, x + 1, y, 1'b1);
            x += 2;
        end else begin
            sample = (word[15:0] > SAMPLE_MAX) ? SAMPLE_MAX : word[15:0];
            s8 = sample[11:4];
            if (y[0] == 1'b0) begin
                line_store[x % MAX_WIDTH] = s8;
            end else if (x[0] == 1'b0) begin
                green_hold = s8;
            end else begin
                blue = line_store[(x - 1) % MAX_WIDTH];
                g_up = line_store[x % MAX_WIDTH];
                push_pixel({ALPHA_RAW, s8, g_up, blue}, x - 1, y - 1, 1'b0);
                push_pixel({ALPHA_RAW, s8, g_up, blue}, x, y - 1, 1'b0);
                push_pixel({ALPHA_RAW, s8, green_hold, blue}, x - 1, y, 1'b0);
                push_pixel({ALPHA_RAW, s8, green_hold, blue}, x, y, 1'b1);
            end
            x += 1;
        end
        if (x >= w) begin
            x = 0;
            y += 1;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    // called at a clock edge; valid stays high after the request so back-to-back
    // words need no second assignment in one step
    task automatic send_word(input logic [31:0] word, input logic typed,
                             input logic [31:0] typed_color);
        if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel_word <= word;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(word, typed, typed_color);
    endtask

    task automatic drain();
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_in_valid <= 1'b0;
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FORMAT: fmt_reg    = data[0];
            REG_WIDTH:  width_reg  = data[SIZE_W-1:0];
            REG_HEIGHT: height_reg = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h (cycle %0d)", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    // output side: check each delivered pixel, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                note_mismatch("unexpected pixel", o_pixel_color, '0);
            end else begin
                oldest = expected_pixels.pop_front();
                if (o_pixel_color !== oldest.color)
                    note_mismatch("pixel_color", o_pixel_color, oldest.color);
                if (o_column !== oldest.col)
                    note_mismatch("column", 32'(o_column), 32'(oldest.col));
                if (o_row !== oldest.row)
                    note_mismatch("row", 32'(o_row), 32'(oldest.row));
                if (o_last !== oldest.last)
                    note_mismatch("last", 32'(o_last), 32'(oldest.last));
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    initial begin
        t_plan_step      st;
        int              phase, k, n;
        logic            fmt_pick;
        logic [31:0]     wsel, hsel;

        fmt_reg    = FMT_YUV;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        col_pos    = 0;
        row_pos    = 0;
        green_hold = 8'd0;

        directed_plan = '{
            // reset settings: YUV, 1280 x 800; black, white and below-black
            '{PLAN_WORD,  REG_FORMAT, 32'h80108010, 1'b1, 32'h80000000},
            '{PLAN_WORD,  REG_FORMAT, 32'h80FF80FF, 1'b1, 32'h80FFFFFF},
            '{PLAN_WORD,  REG_FORMAT, 32'h80008000, 1'b1, 32'h80000000},
            '{PLAN_WORD,  REG_FORMAT, 32'h00000000, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'hFFFFFFFF, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h00FF00FF, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'hFF00FF00, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h5AA5C33C, 1'b0, 32'h0},
            // shrinking the width past the column restarts it
            '{PLAN_WRITE, REG_WIDTH,  32'd4,        1'b0, 32'h0},
            '{PLAN_WRITE, REG_HEIGHT, 32'd4,        1'b0, 32'h0},
            '{PLAN_WRITE, REG_FORMAT, {31'b0, FMT_RAW}, 1'b0, 32'h0},
            // even row: zero, clamped, high bits ignored, just over the clamp
            '{PLAN_WORD,  REG_FORMAT, 32'h00000000, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h0000FFFF, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'hFFFF0FFF, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h00001000, 1'b0, 32'h0},
            // odd row: green, quad, green, quad
            '{PLAN_WORD,  REG_FORMAT, 32'h00000810, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h00000FF0, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h00000123, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'hABCD0000, 1'b0, 32'h0},
            // leave the column odd, then back to YUV
            '{PLAN_WORD,  REG_FORMAT, 32'h00000777, 1'b0, 32'h0},
            '{PLAN_WRITE, REG_FORMAT, {31'b0, FMT_YUV}, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h12345678, 1'b0, 32'h0},
            // row now beyond the height
            '{PLAN_WRITE, REG_HEIGHT, 32'd2,        1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h80EB80EB, 1'b0, 32'h0},
            // sizes below, above and off the legal even range
            '{PLAN_WRITE, REG_WIDTH,  32'd0,        1'b0, 32'h0},
            '{PLAN_WRITE, REG_HEIGHT, 32'd1,        1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h3C5A9610, 1'b0, 32'h0},
            '{PLAN_WRITE, REG_WIDTH,  32'hFFF,      1'b0, 32'h0},
            '{PLAN_WRITE, REG_HEIGHT, 32'hFFF,      1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h7FC0407F, 1'b0, 32'h0},
            '{PLAN_WRITE, REG_WIDTH,  32'd7,        1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'h01020304, 1'b0, 32'h0},
            // unmapped register must change nothing
            '{PLAN_WRITE, REG_SPARE,  32'hFFFFFFFF, 1'b0, 32'h0},
            '{PLAN_WORD,  REG_FORMAT, 32'hC0FFEE00, 1'b0, 32'h0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_gap_pct     = 14;
        receiver_stall_pct = 65;
        for (k = 0; k < PLAN_ROWS; k++) begin
            st = directed_plan[k];
            if (st.kind == PLAN_WRITE)
                write_reg(st.reg_idx, st.value);
            else
                send_word(st.value, st.typed, st.color);
        end

        // walk to the frame origin on a 2 x 2 frame, then fill the part of the
        // line store that RAW frames use, so no later quad reads an unwritten entry
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        write_reg(REG_FORMAT, {31'b0, FMT_YUV});
        write_reg(REG_WIDTH, 32'd2);
        write_reg(REG_HEIGHT, 32'd2);
        while (col_pos == 1 || row_pos == 1)
            send_word(random_word(FMT_YUV), 1'b0, '0);
        write_reg(REG_WIDTH, 32'(FILL_WIDTH));
        write_reg(REG_FORMAT, {31'b0, FMT_RAW});
        for (k = 0; k < FILL_WIDTH; k++)
            send_word(random_word(FMT_RAW), 1'b0, '0);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                sender_gap_pct     = 14;
                receiver_stall_pct = 65;
            end else if (phase < 6) begin
                sender_gap_pct     = 65;
                receiver_stall_pct = 14;
            end else begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            fmt_pick = (phase % 3 == 0) ? FMT_RAW : logic'($urandom_range(1));
            case ($urandom_range(7))
                0:       wsel = 32'(MAX_WIDTH);
                1:       wsel = $urandom_range(4095);
                default: wsel = 2 * $urandom_range(1, 12);
            endcase
            // RAW frames stay inside the filled part of the line store
            if (fmt_pick == FMT_RAW && wsel > 32'(FILL_WIDTH))
                wsel = 2 * $urandom_range(1, FILL_WIDTH / 2);
            case ($urandom_range(7))
                0:       hsel = 32'(MAX_HEIGHT);
                1:       hsel = $urandom_range(4095);
                default: hsel = 2 * $urandom_range(1, 4);
            endcase
            write_reg(REG_FORMAT, {31'b0, fmt_pick});
            write_reg(REG_WIDTH, wsel);
            write_reg(REG_HEIGHT, hsel);
            // long output hold while requests keep coming: fills the block
            if (phase == 1 || phase == 7) hold_requests++;
            n = $urandom_range(10, 16);
            for (k = 0; k < n; k++)
                send_word(random_word(fmt_pick), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        drain();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
